### hdl/hat_pkg.sv
// Shared types, register indexes and widths of the hangover activity trigger.
`timescale 1ns / 1ps
`default_nettype none
package hat_pkg;

   localparam int SampleWidth       = 16;
   localparam int SampleBitsDefault = 16;
   localparam int DataWidth         = 32;
   localparam int HangWidth         = 16;
   localparam int AddrWidth         = 5;
   localparam int IndexWidth        = 3;
   localparam int FifoDepth         = 4;

   // register indexes, byte address is 4 * index
   localparam logic [IndexWidth-1:0] RegModeFlags         = 3'd0;
   localparam logic [IndexWidth-1:0] RegHangoverIn        = 3'd1;
   localparam logic [IndexWidth-1:0] RegHangoverOut       = 3'd2;
   localparam logic [IndexWidth-1:0] RegMinDuration       = 3'd3;
   localparam logic [IndexWidth-1:0] RegMaxDuration       = 3'd4;
   localparam logic [IndexWidth-1:0] RegIncrementInterval = 3'd5;
   localparam logic [IndexWidth-1:0] RegLowerOffset       = 3'd6;
   localparam logic [IndexWidth-1:0] RegUpperOffset       = 3'd7;

   localparam logic StatusContinued = 1'b0;
   localparam logic StatusCompleted = 1'b1;

   typedef struct packed {
      logic                 all_chan;
      logic                 eager_en;
      logic [HangWidth-1:0] hangover_in;
      logic [HangWidth-1:0] hangover_out;
      logic [DataWidth-1:0] min_duration;
      logic [DataWidth-1:0] max_duration;
      logic [DataWidth-1:0] increment_interval;
      logic [DataWidth-1:0] lower_offset;
      logic [DataWidth-1:0] upper_offset;
   } cfg_type;

   // decisions of one closed frame, handed to the report stage
   typedef struct packed {
      logic                 eager;
      logic                 cont;
      logic                 comp;
      logic [DataWidth-1:0] start;
      logic [DataWidth-1:0] cont_now;
      logic [DataWidth-1:0] cont_dur;
      logic [DataWidth-1:0] comp_now;
      logic [DataWidth-1:0] comp_dur;
   } event_type;

   typedef struct packed {
      logic [DataWidth-1:0] event_start;
      logic [DataWidth-1:0] event_length;
      logic                 status;
      logic                 last;
   } result_type;

endpackage
`default_nettype wire

### hdl/hangover_activity_trigger.sv
// Top level: configuration registers and the tracker and report stages.
//
//   port group   dir   handshake               payload
//   req_*        in    req_valid / req_ready   req_sample, req_frame_end
//   rsp_*        out   rsp_valid / rsp_ready   rsp_event_start, rsp_event_length,
//                                              rsp_status, rsp_last
//   csr_*        in    psel/penable/pready     csr_paddr, csr_pwdata, csr_prdata
//
// One item per cycle is accepted unless stalled; tracker updates all frame state at once.
// A frame end goes via the input and event registers to the result queue and rsp_valid.
// A frame end with two results needs two output transfers; a 4-entry queue absorbs this.
// Reset clears state and control registers, not the data registers; no clearing pass.
// An rsp stall fills the queue, then holds the event and input registers, then req_ready.
`timescale 1ns / 1ps
`default_nettype none
module hangover_activity_trigger #(
   parameter int SAMPLE_BITS = hat_pkg::SampleBitsDefault
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  signed [hat_pkg::SampleWidth-1:0] req_sample,
   input  wire                                    req_frame_end,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic [hat_pkg::DataWidth-1:0]          rsp_event_start,
   output logic [hat_pkg::DataWidth-1:0]          rsp_event_length,
   output logic                                   rsp_status,
   output logic                                   rsp_last,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [hat_pkg::AddrWidth-1:0]          csr_paddr,
   input  wire  [hat_pkg::DataWidth-1:0]          csr_pwdata,
   output logic [hat_pkg::DataWidth-1:0]          csr_prdata,
   output logic                                   csr_pready
);

   logic [1:0]                     mode_flags_ff;
   logic [hat_pkg::HangWidth-1:0]  hangover_in_ff;
   logic [hat_pkg::HangWidth-1:0]  hangover_out_ff;
   logic [hat_pkg::DataWidth-1:0]  min_duration_ff;
   logic [hat_pkg::DataWidth-1:0]  max_duration_ff;
   logic [hat_pkg::DataWidth-1:0]  increment_interval_ff;
   logic [hat_pkg::DataWidth-1:0]  lower_offset_ff;
   logic [hat_pkg::DataWidth-1:0]  upper_offset_ff;

   logic [hat_pkg::IndexWidth-1:0] csr_index;
   logic                           csr_write;
   hat_pkg::cfg_type               cfg;
   hat_pkg::event_type             ev;
   logic                           ev_valid;
   logic                           ev_ready;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[hat_pkg::AddrWidth-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_flags_ff         <= '0;
         hangover_in_ff        <= '0;
         hangover_out_ff       <= '0;
         min_duration_ff       <= '0;
         max_duration_ff       <= '0;
         increment_interval_ff <= '0;
         lower_offset_ff       <= '0;
         upper_offset_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            hat_pkg::RegModeFlags:         mode_flags_ff         <= csr_pwdata[1:0];
            hat_pkg::RegHangoverIn:        hangover_in_ff        <= csr_pwdata[15:0];
            hat_pkg::RegHangoverOut:       hangover_out_ff       <= csr_pwdata[15:0];
            hat_pkg::RegMinDuration:       min_duration_ff       <= csr_pwdata;
            hat_pkg::RegMaxDuration:       max_duration_ff       <= csr_pwdata;
            hat_pkg::RegIncrementInterval: increment_interval_ff <= csr_pwdata;
            hat_pkg::RegLowerOffset:       lower_offset_ff       <= csr_pwdata;
            hat_pkg::RegUpperOffset:       upper_offset_ff       <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         hat_pkg::RegModeFlags:         csr_prdata = {30'd0, mode_flags_ff};
         hat_pkg::RegHangoverIn:        csr_prdata = {16'd0, hangover_in_ff};
         hat_pkg::RegHangoverOut:       csr_prdata = {16'd0, hangover_out_ff};
         hat_pkg::RegMinDuration:       csr_prdata = min_duration_ff;
         hat_pkg::RegMaxDuration:       csr_prdata = max_duration_ff;
         hat_pkg::RegIncrementInterval: csr_prdata = increment_interval_ff;
         hat_pkg::RegLowerOffset:       csr_prdata = lower_offset_ff;
         hat_pkg::RegUpperOffset:       csr_prdata = upper_offset_ff;
         default:                       csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.all_chan           = mode_flags_ff[0];
      cfg.eager_en           = mode_flags_ff[1];
      cfg.hangover_in        = hangover_in_ff;
      cfg.hangover_out       = hangover_out_ff;
      cfg.min_duration       = min_duration_ff;
      cfg.max_duration       = max_duration_ff;
      cfg.increment_interval = increment_interval_ff;
      cfg.lower_offset       = lower_offset_ff;
      cfg.upper_offset       = upper_offset_ff;
   end

   hat_tracker #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_frame_end (req_frame_end),
      .ev_valid      (ev_valid),
      .ev_ready      (ev_ready),
      .ev            (ev)
   );

   hat_report u_report (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .ev_valid         (ev_valid),
      .ev_ready         (ev_ready),
      .ev               (ev),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_start  (rsp_event_start),
      .rsp_event_length (rsp_event_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   a_hang_in_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index == hat_pkg::RegHangoverIn)
      |=> hangover_in_ff == $past(csr_pwdata[15:0]))
      else $error("hangover_in write lost");

endmodule
`default_nettype wire

### hdl/hat_tracker.sv
// Input register, frame activity and hangover state, event register.
`timescale 1ns / 1ps
`default_nettype none
module hat_tracker #(
   parameter int SAMPLE_BITS = hat_pkg::SampleBitsDefault
) (
   input  wire                                clock,
   input  wire                                reset,
   input  hat_pkg::cfg_type                   cfg,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  signed [hat_pkg::SampleWidth-1:0] req_sample,
   input  wire                                req_frame_end,
   output logic                               ev_valid,
   input  wire                                ev_ready,
   output hat_pkg::event_type                 ev
);

   localparam int TestBits = (SAMPLE_BITS < hat_pkg::SampleWidth) ?
                             SAMPLE_BITS : hat_pkg::SampleWidth;

   logic                           in_valid_ff;
   logic                           in_nz_ff;
   logic                           in_end_ff;
   logic                           take;

   logic [hat_pkg::DataWidth-1:0]  frame_index_ff, frame_index_in;
   logic                           frame_active_ff, frame_active_in;
   logic                           frame_open_ff, frame_open_in;
   logic                           triggered_ff, triggered_in;
   logic [hat_pkg::HangWidth-1:0]  in_count_ff, in_count_in;
   logic [hat_pkg::HangWidth-1:0]  out_count_ff, out_count_in;
   logic [hat_pkg::DataWidth-1:0]  report_count_ff, report_count_in;
   logic [hat_pkg::DataWidth-1:0]  start_frame_ff, start_frame_in;
   logic [hat_pkg::DataWidth-1:0]  stop_frame_ff, stop_frame_in;
   logic                           ev_valid_ff;
   hat_pkg::event_type             ev_ff, ev_in;

   logic                           act;
   logic [hat_pkg::DataWidth-1:0]  rc_dec;

   assign ev_valid  = ev_valid_ff;
   assign ev        = ev_ff;
   assign take      = in_valid_ff && (!ev_valid_ff || ev_ready);
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      if (!frame_open_ff) begin
         act = in_nz_ff;
      end else if (cfg.all_chan) begin
         act = frame_active_ff && in_nz_ff;
      end else begin
         act = frame_active_ff || in_nz_ff;
      end
   end

   assign rc_dec = report_count_ff - 1'b1;

   always_comb begin
      frame_index_in  = frame_index_ff;
      frame_active_in = frame_active_ff;
      frame_open_in   = frame_open_ff;
      triggered_in    = triggered_ff;
      in_count_in     = in_count_ff;
      out_count_in    = out_count_ff;
      report_count_in = report_count_ff;
      start_frame_in  = start_frame_ff;
      stop_frame_in   = stop_frame_ff;
      ev_in           = '0;
      ev_in.start     = start_frame_ff;
      ev_in.cont_now  = frame_index_ff;
      ev_in.cont_dur  = frame_index_ff - start_frame_ff;
      ev_in.comp_now  = stop_frame_ff;
      ev_in.comp_dur  = stop_frame_ff - start_frame_ff;
      if (take) begin
         frame_active_in = act;
         frame_open_in   = !in_end_ff;
         if (in_end_ff) begin
            frame_index_in = frame_index_ff + 1'b1;
            if (!triggered_ff) begin
               if (act) begin
                  if (in_count_ff == cfg.hangover_in) begin
                     start_frame_in = frame_index_ff;
                  end
                  if (in_count_ff == '0) begin
                     triggered_in    = 1'b1;
                     out_count_in    = cfg.hangover_out;
                     report_count_in = cfg.increment_interval -
                                       {{(hat_pkg::DataWidth-hat_pkg::HangWidth){1'b0}},
                                        cfg.hangover_in};
                     ev_in.eager     = cfg.eager_en;
                     ev_in.start     = start_frame_in;
                  end else begin
                     in_count_in = in_count_ff - 1'b1;
                  end
               end else begin
                  in_count_in = cfg.hangover_in;
               end
            end else begin
               if (cfg.increment_interval != '0) begin
                  report_count_in = rc_dec;
                  if (rc_dec == '0) begin
                     ev_in.cont      = 1'b1;
                     report_count_in = cfg.increment_interval;
                  end
               end
               if (!act) begin
                  // the first inactive frame of a run marks the stop
                  if (out_count_ff == cfg.hangover_out) begin
                     stop_frame_in  = frame_index_ff;
                     ev_in.comp_now = frame_index_ff;
                     ev_in.comp_dur = frame_index_ff - start_frame_ff;
                  end
                  if (out_count_ff == '0) begin
                     ev_in.comp   = 1'b1;
                     triggered_in = 1'b0;
                     in_count_in  = cfg.hangover_in;
                  end else begin
                     out_count_in = out_count_ff - 1'b1;
                  end
               end else begin
                  out_count_in = cfg.hangover_out;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         ev_valid_ff     <= 1'b0;
         frame_index_ff  <= '0;
         frame_active_ff <= 1'b0;
         frame_open_ff   <= 1'b0;
         triggered_ff    <= 1'b0;
         in_count_ff     <= '0;
         out_count_ff    <= '0;
         report_count_ff <= '0;
         start_frame_ff  <= '0;
         stop_frame_ff   <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (!ev_valid_ff || ev_ready) begin
            ev_valid_ff <= take && in_end_ff;
         end
         frame_index_ff  <= frame_index_in;
         frame_active_ff <= frame_active_in;
         frame_open_ff   <= frame_open_in;
         triggered_ff    <= triggered_in;
         in_count_ff     <= in_count_in;
         out_count_ff    <= out_count_in;
         report_count_ff <= report_count_in;
         start_frame_ff  <= start_frame_in;
         stop_frame_ff   <= stop_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_nz_ff  <= |req_sample[TestBits-1:0];
         in_end_ff <= req_frame_end;
      end
      if (take) begin
         ev_ff <= ev_in;
      end
   end

   // an eager notice only comes from an idle tracker, never with a report
   a_eager_alone: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff && ev_ff.eager |-> !ev_ff.cont && !ev_ff.comp)
      else $error("eager notice together with a report");

   // a completion drops the trigger
   a_comp_clears: assert property (@(posedge clock) disable iff (reset)
      take && in_end_ff && ev_in.comp |=> !triggered_ff)
      else $error("trigger still set after completion");

endmodule
`default_nettype wire

### hdl/hat_report.sv
// Clamp, filter and offset of reports, and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module hat_report (
   input  wire                                clock,
   input  wire                                reset,
   input  hat_pkg::cfg_type                   cfg,
   input  wire                                ev_valid,
   output logic                               ev_ready,
   input  hat_pkg::event_type                 ev,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [hat_pkg::DataWidth-1:0]      rsp_event_start,
   output logic [hat_pkg::DataWidth-1:0]      rsp_event_length,
   output logic                               rsp_status,
   output logic                               rsp_last
);

   localparam int PtrWidth   = $clog2(hat_pkg::FifoDepth);
   localparam int CountWidth = $clog2(hat_pkg::FifoDepth + 1);

   typedef struct packed {
      logic                          pass;
      logic [hat_pkg::DataWidth-1:0] start;
      logic [hat_pkg::DataWidth-1:0] length;
   } report_type;

   function automatic report_type format_report(
      input hat_pkg::cfg_type              c,
      input logic [hat_pkg::DataWidth-1:0] now,
      input logic [hat_pkg::DataWidth-1:0] dur,
      input logic [hat_pkg::DataWidth-1:0] start
   );
      logic                          clamp;
      logic [hat_pkg::DataWidth-1:0] d;
      logic [hat_pkg::DataWidth-1:0] ts;
      report_type                    r;
      clamp    = (c.max_duration != '0) && (dur > c.max_duration);
      d        = clamp ? c.max_duration : dur;
      ts       = clamp ? (now - c.max_duration) : start;
      r.pass   = (d != '0) && (d >= c.min_duration);
      r.start  = (ts >= c.lower_offset) ? (ts - c.lower_offset) : '0;
      r.length = (d > ~c.upper_offset) ? '1 : (d + c.upper_offset);
      return r;
   endfunction

   hat_pkg::result_type            fifo_mem_ff [hat_pkg::FifoDepth];
   logic [PtrWidth-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]          count_ff, count_in;

   report_type                     rep_cont;
   report_type                     rep_comp;
   hat_pkg::result_type            entry0, entry1;
   logic [1:0]                     push_n;
   logic                           push;
   logic                           pop;
   logic                           use_cont;
   logic                           use_comp;

   assign rep_cont = format_report(cfg, ev.cont_now, ev.cont_dur, ev.start);
   assign rep_comp = format_report(cfg, ev.comp_now, ev.comp_dur, ev.start);
   assign use_cont = ev.cont && rep_cont.pass;
   assign use_comp = ev.comp && rep_comp.pass;

   // pack the surviving results in order, continued before completed
   always_comb begin
      entry0 = '0;
      entry1 = '0;
      push_n = 2'd0;
      if (ev.eager) begin
         entry0.event_start = ev.start;
         entry0.status      = hat_pkg::StatusContinued;
         entry0.last        = 1'b1;
         push_n             = 2'd1;
      end else if (use_cont) begin
         entry0.event_start  = rep_cont.start;
         entry0.event_length = rep_cont.length;
         entry0.status       = hat_pkg::StatusContinued;
         entry0.last         = !use_comp;
         entry1.event_start  = rep_comp.start;
         entry1.event_length = rep_comp.length;
         entry1.status       = hat_pkg::StatusCompleted;
         entry1.last         = 1'b1;
         push_n              = use_comp ? 2'd2 : 2'd1;
      end else if (use_comp) begin
         entry0.event_start  = rep_comp.start;
         entry0.event_length = rep_comp.length;
         entry0.status       = hat_pkg::StatusCompleted;
         entry0.last         = 1'b1;
         push_n              = 2'd1;
      end
   end

   // take an event only with room for two results
   assign ev_ready  = count_ff <= CountWidth'(hat_pkg::FifoDepth - 2);
   assign push      = ev_valid && ev_ready;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_event_start  = fifo_mem_ff[rd_ptr_ff].event_start;
   assign rsp_event_length = fifo_mem_ff[rd_ptr_ff].event_length;
   assign rsp_status       = fifo_mem_ff[rd_ptr_ff].status;
   assign rsp_last         = fifo_mem_ff[rd_ptr_ff].last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(push_n);
         count_in  = count_in + CountWidth'(push_n);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && (push_n != 2'd0)) begin
         fifo_mem_ff[wr_ptr_ff] <= entry0;
      end
      if (push && (push_n == 2'd2)) begin
         fifo_mem_ff[PtrWidth'(wr_ptr_ff + 1'b1)] <= entry1;
      end
   end

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(hat_pkg::FifoDepth))
      else $error("result queue overflow");

endmodule
`default_nettype wire

### verif/tb_hangover_activity_trigger.sv
// Testbench for the hangover activity trigger: predicts events and checks every result.
`timescale 1ns / 1ps
module tb_hangover_activity_trigger;

   typedef enum int {FrameOn, FrameOff, FrameMixed} frame_kind_type;

   // Tracks frame activity and the event state, and holds the events still to come out.
   class event_scoreboard_type;
      logic                          all_chan, eager_en;
      logic [hat_pkg::HangWidth-1:0] hang_in, hang_out;
      logic [hat_pkg::DataWidth-1:0] min_dur, max_dur, interval, lo_off, up_off;
      logic [hat_pkg::DataWidth-1:0] frame_idx, in_cnt, out_cnt, rep_cnt, start_f, stop_f;
      bit                            acc_active, frame_open, armed;
      hat_pkg::result_type           step_events[$];
      hat_pkg::result_type           pending_events[$];
      int                            errors;

      function new();
         all_chan = 0; eager_en = 0; hang_in = '0; hang_out = '0;
         min_dur = '0; max_dur = '0; interval = '0; lo_off = '0; up_off = '0;
         frame_idx = '0; in_cnt = '0; out_cnt = '0; rep_cnt = '0;
         start_f = '0; stop_f = '0;
         acc_active = 0; frame_open = 0; armed = 0; errors = 0;
      endfunction

      function void write_reg(logic [hat_pkg::IndexWidth-1:0] idx,
                              logic [hat_pkg::DataWidth-1:0] v);
         case (idx)
            hat_pkg::RegModeFlags: begin
               all_chan = v[0];
               eager_en = v[1];
            end
            hat_pkg::RegHangoverIn:        hang_in = v[hat_pkg::HangWidth-1:0];
            hat_pkg::RegHangoverOut:       hang_out = v[hat_pkg::HangWidth-1:0];
            hat_pkg::RegMinDuration:       min_dur = v;
            hat_pkg::RegMaxDuration:       max_dur = v;
            hat_pkg::RegIncrementInterval: interval = v;
            hat_pkg::RegLowerOffset:       lo_off = v;
            hat_pkg::RegUpperOffset:       up_off = v;
            default: ;
         endcase
      endfunction

      function logic [hat_pkg::DataWidth-1:0] reg_value(logic [hat_pkg::IndexWidth-1:0] idx);
         case (idx)
            hat_pkg::RegModeFlags:         return {30'd0, eager_en, all_chan};
            hat_pkg::RegHangoverIn:        return {16'd0, hang_in};
            hat_pkg::RegHangoverOut:       return {16'd0, hang_out};
            hat_pkg::RegMinDuration:       return min_dur;
            hat_pkg::RegMaxDuration:       return max_dur;
            hat_pkg::RegIncrementInterval: return interval;
            hat_pkg::RegLowerOffset:       return lo_off;
            default:                       return up_off;
         endcase
      endfunction

      function int pending();
         return pending_events.size();
      endfunction

      function void push_event(logic [hat_pkg::DataWidth-1:0] s,
                               logic [hat_pkg::DataWidth-1:0] len, logic st);
         hat_pkg::result_type r;
         r.event_start = s;
         r.event_length = len;
         r.status = st;
         r.last = 1'b0;
         if (step_events.size() < 2) step_events.push_back(r);
      endfunction

      // clamp to max duration, drop short events, then apply the offsets
      function void add_report(logic [hat_pkg::DataWidth-1:0] now, logic st);
         logic [hat_pkg::DataWidth-1:0] dur, t, s, len;
         dur = now - start_f;
         t = start_f;
         if (max_dur != 0 && dur > max_dur) begin
            dur = max_dur;
            t = now - max_dur;
         end
         if (dur == 0 || dur < min_dur) return;
         s = (t >= lo_off) ? t - lo_off : '0;
         len = (dur > 32'hFFFF_FFFF - up_off) ? 32'hFFFF_FFFF : dur + up_off;
         push_event(s, len, st);
      endfunction

      function void note_sample(logic [hat_pkg::SampleWidth-1:0] sample, logic fe);
         bit                            nz, act;
         logic [hat_pkg::DataWidth-1:0] now;
         nz = (sample != '0);
         if (!frame_open) act = nz;
         else act = all_chan ? (acc_active && nz) : (acc_active || nz);
         acc_active = act;
         if (!fe) begin
            frame_open = 1;
            return;
         end
         frame_open = 0;
         now = frame_idx;
         step_events.delete();
         if (!armed) begin
            if (act) begin
               if (in_cnt == {16'd0, hang_in}) start_f = now;
               if (in_cnt == 0) begin
                  armed = 1;
                  out_cnt = {16'd0, hang_out};
                  rep_cnt = interval - {16'd0, hang_in};
                  if (eager_en) push_event(start_f, '0, hat_pkg::StatusContinued);
               end else begin
                  in_cnt = in_cnt - 1;
               end
            end else begin
               in_cnt = {16'd0, hang_in};
            end
         end else begin
            if (interval != 0) begin
               rep_cnt = rep_cnt - 1;
               if (rep_cnt == 0) begin
                  add_report(now, hat_pkg::StatusContinued);
                  rep_cnt = interval;
               end
            end
            if (!act) begin
               if (out_cnt == {16'd0, hang_out}) stop_f = now;
               if (out_cnt == 0) begin
                  add_report(stop_f, hat_pkg::StatusCompleted);
                  armed = 0;
                  in_cnt = {16'd0, hang_in};
               end else begin
                  out_cnt = out_cnt - 1;
               end
            end else begin
               out_cnt = {16'd0, hang_out};
            end
         end
         frame_idx = now + 1;
         foreach (step_events[i]) begin
            step_events[i].last = (i == step_events.size() - 1);
            pending_events.push_back(step_events[i]);
         end
      endfunction

      function void check_event(logic [hat_pkg::DataWidth-1:0] s,
                                logic [hat_pkg::DataWidth-1:0] len,
                                logic st, logic lst);
         hat_pkg::result_type exp_r;
         if (pending_events.size() == 0) begin
            $error("unexpected result: event_start %0h event_length %0h status %0b last %0b",
                   s, len, st, lst);
            errors++;
            return;
         end
         exp_r = pending_events.pop_front();
         if (s !== exp_r.event_start) begin
            $error("event_start: expected %0h, got %0h", exp_r.event_start, s);
            errors++;
         end
         if (len !== exp_r.event_length) begin
            $error("event_length: expected %0h, got %0h", exp_r.event_length, len);
            errors++;
         end
         if (st !== exp_r.status) begin
            $error("status: expected %0b, got %0b", exp_r.status, st);
            errors++;
         end
         if (lst !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [hat_pkg::SampleWidth-1:0] req_sample = '0;
   logic                                   req_frame_end = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [hat_pkg::DataWidth-1:0]          rsp_event_start, rsp_event_length;
   logic                                   rsp_status, rsp_last;
   logic                                   csr_psel = 1'b0;
   logic                                   csr_penable = 1'b0;
   logic                                   csr_pwrite = 1'b0;
   logic [hat_pkg::AddrWidth-1:0]          csr_paddr = '0;
   logic [hat_pkg::DataWidth-1:0]          csr_pwdata = '0;
   logic [hat_pkg::DataWidth-1:0]          csr_prdata;
   logic                                   csr_pready;

   event_scoreboard_type sb = new();
   int  items_sent = 0;
   int  send_idle = 0;
   int  recv_stall = 0;
   int  cur_hin = 0;
   int  cur_hout = 0;
   int  hold_left = 0;
   bit  hold_request = 0;

   hangover_activity_trigger u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_start  (rsp_event_start),
      .rsp_event_length (rsp_event_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_sample, req_frame_end);
         if (rsp_valid && rsp_ready)
            sb.check_event(rsp_event_start, rsp_event_length, rsp_status, rsp_last);
      end
   end

   // receiver: random stalls, or a long hold-off when asked for
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 300;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_item(logic [hat_pkg::SampleWidth-1:0] s, logic fe);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_frame_end <= fe;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   function automatic logic [hat_pkg::SampleWidth-1:0] pick_nonzero();
      logic [hat_pkg::SampleWidth-1:0] v;
      v = 16'($urandom);
      case ($urandom_range(7))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         default: ;
      endcase
      if (v == 0) v = 16'h0001;
      return v;
   endfunction

   task automatic send_frame(int nch, frame_kind_type kind);
      logic [hat_pkg::SampleWidth-1:0] s;
      for (int ch = 0; ch < nch; ch++) begin
         case (kind)
            FrameOn:  s = pick_nonzero();
            FrameOff: s = '0;
            default:  s = $urandom_range(1) ? pick_nonzero() : '0;
         endcase
         send_item(s, ch == nch - 1);
      end
   endtask

   // drop valid, wait for every expected result, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(logic [hat_pkg::IndexWidth-1:0] idx,
                                 logic [hat_pkg::DataWidth-1:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, v);
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== sb.reg_value(idx)) begin
         $error("register %0d: expected %0h, got %0h", idx, sb.reg_value(idx), csr_prdata);
         sb.errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_setting(logic [1:0] mode, logic [15:0] hin, logic [15:0] hout,
                                logic [31:0] mind, logic [31:0] maxd, logic [31:0] inc,
                                logic [31:0] lo, logic [31:0] up);
      write_register(hat_pkg::RegModeFlags, {30'd0, mode});
      write_register(hat_pkg::RegHangoverIn, {16'd0, hin});
      write_register(hat_pkg::RegHangoverOut, {16'd0, hout});
      write_register(hat_pkg::RegMinDuration, mind);
      write_register(hat_pkg::RegMaxDuration, maxd);
      write_register(hat_pkg::RegIncrementInterval, inc);
      write_register(hat_pkg::RegLowerOffset, lo);
      write_register(hat_pkg::RegUpperOffset, up);
      cur_hin = int'(hin);
      cur_hout = int'(hout);
   endtask

   task automatic apply_phase(int p);
      case (p)
         0: apply_setting(2'd0, 16'd1, 16'd2, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0);
         1: apply_setting(2'd1, 16'd2, 16'd0, 32'd3, 32'd5, 32'd1, 32'd1, 32'd2);
         2: apply_setting(2'd2, 16'd0, 16'd1, 32'd0, 32'd1, 32'd2,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF);
         // interval equal to hangover_in: the report counter loads zero
         3: apply_setting(2'd3, 16'd3, 16'd3, 32'd2, 32'd0, 32'd3, 32'd2, 32'd7);
         // interval below hangover_in: the counter load wraps
         4: apply_setting(2'd2, 16'd2, 16'd1, 32'd0, 32'd4, 32'd1, 32'd0, 32'hFFFF_FFF0);
         5: apply_setting(2'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'd0, 32'd0);
         6: apply_setting(2'd1, 16'd0, 16'd0, 32'd1, 32'd2, 32'd1, 32'd3, 32'd1);
         default: apply_setting(2'($urandom_range(3)), 16'($urandom_range(3)),
                                16'($urandom_range(3)), $urandom_range(3),
                                $urandom_range(6), $urandom_range(4),
                                $urandom_range(5), $urandom_range(3));
      endcase
   endtask

   task automatic run_stream(int count);
      int target, nch, on_len, off_len, span_in, span_out;
      target = items_sent + count;
      span_in = (cur_hin > 6) ? 6 : cur_hin;
      span_out = (cur_hout > 6) ? 6 : cur_hout;
      while (items_sent < target) begin
         if ($urandom_range(99) < 25) begin
            send_item($urandom_range(1) ? pick_nonzero() : 16'd0, 1'($urandom_range(1)));
         end else begin
            nch = $urandom_range(1, 4);
            on_len = $urandom_range(1, span_in + 3);
            off_len = $urandom_range(1, span_out + 3);
            repeat (on_len) send_frame(nch, ($urandom_range(4) == 0) ? FrameMixed : FrameOn);
            repeat (off_len) send_frame(nch, ($urandom_range(4) == 0) ? FrameMixed : FrameOff);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: any channel, no hangover, no reports while running
      send_item(16'h7FFF, 1'b1);
      send_item(16'h0000, 1'b0);
      send_item(16'h8000, 1'b1);
      send_item(16'h0000, 1'b0);
      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b1);
      send_item(16'h0001, 1'b1);
      send_item(16'h0000, 1'b1);
      settle();
      // all-channel mode with eager notice and a report every frame
      write_register(hat_pkg::RegModeFlags, 32'd3);
      write_register(hat_pkg::RegIncrementInterval, 32'd1);
      send_item(16'h0001, 1'b0);
      send_item(16'h0000, 1'b1);
      send_item(16'h8000, 1'b0);
      send_item(16'h7FFF, 1'b1);
      send_item(16'h5555, 1'b0);
      send_item(16'hAAAA, 1'b1);
      // continued report and completion from the same frame
      send_item(16'h0000, 1'b0);
      send_item(16'h1234, 1'b1);

      for (int p = 0; p < 8; p++) begin
         settle();
         apply_phase(p);
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 61; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 61; end
            default: begin send_idle = 37; recv_stall = 37; end
         endcase
         run_stream(80);
      end

      // back-pressure: hold the receiver off while every frame after the trigger yields a report
      settle();
      send_idle = 0;
      recv_stall = 0;
      apply_setting(2'd0, 16'd0, 16'd3, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
      @(posedge clock);
      hold_request = 1;
      repeat (40) send_frame(1, FrameOn);
      repeat (5) send_frame(1, FrameOff);

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
hdl/hat_pkg.sv
hdl/hat_tracker.sv
hdl/hat_report.sv
hdl/hangover_activity_trigger.sv
verif/tb_hangover_activity_trigger.sv
